### rtl/tpd_pkg.sv
// Shared types, constants and helper functions for the terminated packet deframer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package tpd_pkg;

	localparam int MAX_TERM    = 4;
	localparam int LEN_BITS    = 16;
	localparam int BYTE_W      = 8;
	localparam int TERM_W      = 3;
	localparam int TBYTES_W    = 32;
	localparam int CNT_W       = 17;
	localparam int MP_W        = $clog2(MAX_TERM + 1);
	localparam int PH_W        = $clog2(MAX_TERM + 3);
	localparam int CMDQ_DEPTH  = 2;
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 4;
	localparam int REG_IDX_W   = 2;

	// register index codes (paddr[3:2])
	localparam logic [REG_IDX_W-1:0] REG_MAX_LEN    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TERM_LEN   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TERM_BYTES = 2'd2;

	// one command from front to back: held bytes, then rx byte, then end marker
	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic              emit_b;
		logic [MP_W-1:0]   rel;
		logic              marker;
		logic              by_term;
		logic [CNT_W-1:0]  len;
	} cmd_t;

	// terminator length as used: values above MAX_TERM saturate
	function automatic logic [MP_W-1:0] eff_tl(input logic [TERM_W-1:0] tl);
		logic [MP_W-1:0] r;
		if (32'(tl) > MAX_TERM)
			r = MP_W'(MAX_TERM);
		else
			r = MP_W'(tl);
		return r;
	endfunction

	// terminator byte i; bytes past the fourth read as zero
	function automatic logic [BYTE_W-1:0] term_byte(input logic [TBYTES_W-1:0] tb,
	                                                input logic [MP_W-1:0] i);
		logic [TBYTES_W-1:0] s;
		logic [BYTE_W-1:0]   r;
		s = tb >> {i, 3'b000};
		if (32'(i) >= TBYTES_W / BYTE_W)
			r = '0;
		else
			r = s[BYTE_W-1:0];
		return r;
	endfunction

endpackage

### rtl/tpd_front.sv
// Front end: accepts rx bytes, tracks byte count and terminator match, emits commands.
// Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [tpd_pkg::BYTE_W-1:0]      rx_byte,
	input  logic                            clr,
	input  logic [tpd_pkg::LEN_BITS-1:0]    max_len,
	input  logic [tpd_pkg::TERM_W-1:0]      term_len,
	input  logic [tpd_pkg::TBYTES_W-1:0]    term_bytes,
	output logic                            q_wr,
	output tpd_pkg::cmd_t                   q_data
);

	logic [tpd_pkg::CNT_W-1:0] byte_count_q, bc_n, bc_d;
	logic [tpd_pkg::MP_W-1:0]  match_pos_q, mp_d, mp0, mp1, rel_a, tl;
	logic                      accept, hit;

	assign accept = push && !full;

	always_comb begin
		tl     = tpd_pkg::eff_tl(term_len);
		bc_n   = byte_count_q + tpd_pkg::CNT_W'(1);
		mp0    = (match_pos_q >= tl) ? '0 : match_pos_q;
		hit    = (rx_byte == tpd_pkg::term_byte(term_bytes, mp0));
		q_data = '0;
		q_data.rx = rx_byte;
		bc_d   = bc_n;
		mp_d   = '0;
		mp1    = '0;
		rel_a  = '0;
		if (tl == '0) begin
			q_data.emit_b = 1'b1;
			if (bc_n >= tpd_pkg::CNT_W'(max_len)) begin
				q_data.marker = 1'b1;
				q_data.len    = bc_n;
				bc_d          = '0;
			end
		end else begin
			if (hit) begin
				mp1 = mp0 + tpd_pkg::MP_W'(1);
			end else begin
				rel_a         = mp0;
				q_data.emit_b = 1'b1;
			end
			q_data.rel = rel_a;
			if (mp1 >= tl) begin
				q_data.marker  = 1'b1;
				q_data.by_term = 1'b1;
				q_data.len     = bc_n - tpd_pkg::CNT_W'(tl);
				bc_d           = '0;
			end else if (bc_n >= tpd_pkg::CNT_W'(max_len) + tpd_pkg::CNT_W'(tl)) begin
				// length limit: held bytes go out as payload
				q_data.marker = 1'b1;
				q_data.rel    = rel_a + mp1;
				q_data.len    = bc_n;
				bc_d          = '0;
			end else begin
				mp_d = mp1;
			end
		end
		q_wr = accept && (q_data.emit_b || q_data.marker);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			match_pos_q  <= '0;
		end else if (clr) begin
			byte_count_q <= '0;
			match_pos_q  <= '0;
		end else if (accept) begin
			byte_count_q <= bc_d;
			match_pos_q  <= mp_d;
		end
	end

endmodule

### rtl/tpd_cmdq.sv
// Short command queue between front and back ends.
// Depends on tpd_pkg (cmd_t, CMDQ_DEPTH).
`timescale 1ns / 1ps

module tpd_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tpd_pkg::cmd_t wdata,
	input  logic          rd,
	output tpd_pkg::cmd_t rdata,
	output logic          full,
	output logic          nempty
);

	localparam int PTR_W = (tpd_pkg::CMDQ_DEPTH > 1) ? $clog2(tpd_pkg::CMDQ_DEPTH) : 1;
	localparam int CNT_QW = $clog2(tpd_pkg::CMDQ_DEPTH + 1);

	tpd_pkg::cmd_t       mem_q [tpd_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0]    wp_q, rp_q;
	logic [CNT_QW-1:0]   cnt_q;
	logic                do_wr, do_rd;

	assign full   = (cnt_q == CNT_QW'(tpd_pkg::CMDQ_DEPTH));
	assign nempty = (cnt_q != '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && nempty;
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (32'(wp_q) == tpd_pkg::CMDQ_DEPTH - 1) ? '0 : wp_q + PTR_W'(1);
			if (do_rd)
				rp_q <= (32'(rp_q) == tpd_pkg::CMDQ_DEPTH - 1) ? '0 : rp_q + PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNT_QW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNT_QW'(1);
		end
	end

endmodule

### rtl/tpd_back.sv
// Back end: steps commands into the output register, one result per unstalled cycle.
// Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nempty,
	input  tpd_pkg::cmd_t                 q_data,
	output logic                          q_rd,
	input  logic [tpd_pkg::TBYTES_W-1:0]  term_bytes,
	input  logic                          pop,
	output logic                          empty,
	output logic [tpd_pkg::BYTE_W-1:0]    data_byte,
	output logic                          has_data,
	output logic                          last,
	output logic                          by_terminator,
	output logic [tpd_pkg::CNT_W-1:0]     packet_length
);

	logic [tpd_pkg::PH_W-1:0]   ph_q, rel_e, last_ph;
	logic                       out_v_q, adv, is_last;
	logic [tpd_pkg::BYTE_W-1:0] data_q, data_d;
	logic                       hd_q, hd_d, last_q, last_d, bt_q, bt_d;
	logic [tpd_pkg::CNT_W-1:0]  len_q, len_d;

	always_comb begin
		adv     = q_nempty && (!out_v_q || pop);
		rel_e   = tpd_pkg::PH_W'(q_data.rel);
		last_ph = rel_e + tpd_pkg::PH_W'(q_data.emit_b) + tpd_pkg::PH_W'(q_data.marker)
		          - tpd_pkg::PH_W'(1);
		is_last = (ph_q == last_ph);
		data_d  = '0;
		hd_d    = 1'b1;
		last_d  = 1'b0;
		bt_d    = 1'b0;
		len_d   = '0;
		if (ph_q < rel_e) begin
			// held terminator prefix byte
			data_d = tpd_pkg::term_byte(term_bytes, ph_q[tpd_pkg::MP_W-1:0]);
		end else if (ph_q == rel_e && q_data.emit_b) begin
			data_d = q_data.rx;
		end else begin
			hd_d   = 1'b0;
			last_d = 1'b1;
			bt_d   = q_data.by_term;
			len_d  = q_data.len;
		end
		q_rd = adv && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
			ph_q    <= is_last ? '0 : ph_q + tpd_pkg::PH_W'(1);
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= data_d;
			hd_q   <= hd_d;
			last_q <= last_d;
			bt_q   <= bt_d;
			len_q  <= len_d;
		end
	end

	assign empty         = !out_v_q;
	assign data_byte     = data_q;
	assign has_data      = hd_q;
	assign last          = last_q;
	assign by_terminator = bt_q;
	assign packet_length = len_q;

endmodule

### rtl/terminated_packet_deframer.sv
// Top level of the terminated packet deframer: APB registers, front, queue, back.
// Depends on tpd_pkg, tpd_front, tpd_cmdq, tpd_back.
//
// channel   ports                                   handshake
// -------   -------------------------------------   ---------------------------------
// input     rx_byte                                 push & !full
// results   data_byte has_data last by_terminator   pop & !empty
//           packet_length
// config    paddr pwdata prdata                     psel & penable & pwrite (pready=1)
//
// The front takes one item per cycle whenever the command queue has room. The
// back writes one result per cycle into the output register while results
// are popped, so an item occupies the back for one step per result it causes
// (0 to 5: up to 3 held bytes, the byte itself and the end marker); the
// back's one-result-per-cycle sequencer sets the sustained rate.
// Reset clears the registers (max_len 1), the match state and both queues.
// A stalled output holds its result while the front keeps accepting until the
// two-entry queue fills.
`timescale 1ns / 1ps

module terminated_packet_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	// input queue side
	input  logic                            push,
	output logic                            full,
	input  logic [tpd_pkg::BYTE_W-1:0]      rx_byte,
	// result queue side
	output logic                            empty,
	input  logic                            pop,
	output logic [tpd_pkg::BYTE_W-1:0]      data_byte,
	output logic                            has_data,
	output logic                            last,
	output logic                            by_terminator,
	output logic [tpd_pkg::CNT_W-1:0]       packet_length,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tpd_pkg::APB_AW-1:0]      paddr,
	input  logic [tpd_pkg::APB_DW-1:0]      pwdata,
	output logic [tpd_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);

	logic [tpd_pkg::LEN_BITS-1:0]  max_len_q;
	logic [tpd_pkg::TERM_W-1:0]    term_len_q;
	logic [tpd_pkg::TBYTES_W-1:0]  term_bytes_q;
	logic [tpd_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr, cfg_hit;

	logic          q_wr, q_rd, q_nempty;
	tpd_pkg::cmd_t q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[tpd_pkg::APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// a write to any known register abandons the packet in progress
	always_comb begin
		case (reg_idx)
			tpd_pkg::REG_MAX_LEN: begin
				cfg_hit = 1'b1;
				prdata  = tpd_pkg::APB_DW'(max_len_q);
			end
			tpd_pkg::REG_TERM_LEN: begin
				cfg_hit = 1'b1;
				prdata  = tpd_pkg::APB_DW'(term_len_q);
			end
			tpd_pkg::REG_TERM_BYTES: begin
				cfg_hit = 1'b1;
				prdata  = term_bytes_q;
			end
			default: begin
				cfg_hit = 1'b0;
				prdata  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= tpd_pkg::LEN_BITS'(1);
			term_len_q   <= '0;
			term_bytes_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				tpd_pkg::REG_MAX_LEN:    max_len_q    <= pwdata[tpd_pkg::LEN_BITS-1:0];
				tpd_pkg::REG_TERM_LEN:   term_len_q   <= pwdata[tpd_pkg::TERM_W-1:0];
				tpd_pkg::REG_TERM_BYTES: term_bytes_q <= pwdata[tpd_pkg::TBYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// front: classify each item into a command
	tpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.clr        (cfg_wr && cfg_hit),
		.max_len    (max_len_q),
		.term_len   (term_len_q),
		.term_bytes (term_bytes_q),
		.q_wr       (q_wr),
		.q_data     (q_wdata)
	);

	// decoupling queue; its full flag is the input side's full
	tpd_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (full),
		.nempty (q_nempty)
	);

	// back: expand commands into result items
	tpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_nempty      (q_nempty),
		.q_data        (q_rdata),
		.q_rd          (q_rd),
		.term_bytes    (term_bytes_q),
		.pop           (pop),
		.empty         (empty),
		.data_byte     (data_byte),
		.has_data      (has_data),
		.last          (last),
		.by_terminator (by_terminator),
		.packet_length (packet_length)
	);

endmodule

### rtl/tpd_checker.sv
// Port-level checks for the terminated packet deframer, attached by bind.
// Depends on terminated_packet_deframer's port list and tpd_pkg widths.
`timescale 1ns / 1ps

module tpd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [tpd_pkg::BYTE_W-1:0]    data_byte,
	input logic                          has_data,
	input logic                          last,
	input logic                          by_terminator,
	input logic [tpd_pkg::CNT_W-1:0]     packet_length,
	input logic                          pready
);

	// an item not taken stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(data_byte) && $stable(has_data)
		&& $stable(packet_length))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> has_data != last)
		else $error("result is neither payload nor end marker");

	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && has_data |-> packet_length == '0 && !by_terminator)
		else $error("payload item carries end marker fields");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last |-> data_byte == '0)
		else $error("end marker carries a data byte");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind terminated_packet_deframer tpd_checker u_tpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.data_byte     (data_byte),
	.has_data      (has_data),
	.last          (last),
	.by_terminator (by_terminator),
	.packet_length (packet_length),
	.pready        (pready)
);

### tb/testbench.sv
// Self-checking testbench for terminated_packet_deframer: directed and random byte streams.
// Depends on tpd_pkg and the RTL top level; needs no other file.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ITEMS   = 380;
	localparam int DRAIN_CYCLES   = 16;   // front plus up to five results, with margin
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;
	// paddr[3:2] == 3 decodes to no register
	localparam logic [tpd_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [tpd_pkg::BYTE_W-1:0] data_byte;
		logic                       has_data;
		logic                       last;
		logic                       by_terminator;
		logic [tpd_pkg::CNT_W-1:0]  packet_length;
	} frame_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [tpd_pkg::BYTE_W-1:0] rx_byte;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [tpd_pkg::BYTE_W-1:0] data_byte;
	logic                       has_data;
	logic                       last;
	logic                       by_terminator;
	logic [tpd_pkg::CNT_W-1:0]  packet_length;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [tpd_pkg::APB_AW-1:0] paddr;
	logic [tpd_pkg::APB_DW-1:0] pwdata;
	logic [tpd_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	// shadow of the block: registers plus packet state
	logic [15:0]                cur_max_len;
	logic [2:0]                 cur_term_len;
	logic [31:0]                cur_term_bytes;
	logic [tpd_pkg::CNT_W-1:0]  rx_count;     // bytes of this packet so far, held ones included
	logic [2:0]                 held_count;   // terminator prefix currently held back

	frame_result_t     pending_results[$];
	int                error_count = 0;
	int                stall_cycles = 0;
	bit                steady = 1'b0;   // no idling on either side while set

	terminated_packet_deframer u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop), .data_byte(data_byte), .has_data(has_data),
		.last(last), .by_terminator(by_terminator), .packet_length(packet_length),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	// terminator length as the block uses it: anything above MAX_TERM saturates
	function automatic int active_term_len();
		int r;
		if (int'(cur_term_len) > tpd_pkg::MAX_TERM)
			r = tpd_pkg::MAX_TERM;
		else
			r = int'(cur_term_len);
		return r;
	endfunction

	// bytes past the fourth read as zero
	function automatic logic [7:0] term_byte_at(input int i);
		logic [7:0] r;
		if (i >= 4)
			r = '0;
		else
			r = cur_term_bytes[8*i +: 8];
		return r;
	endfunction

	task automatic push_payload(input logic [7:0] b);
		pending_results.push_back('{b, 1'b1, 1'b0, 1'b0, '0});
	endtask

	task automatic push_marker(input logic by_term, input logic [tpd_pkg::CNT_W-1:0] len);
		pending_results.push_back('{'0, 1'b0, 1'b1, by_term, len});
	endtask

	// held bytes are exactly the terminator prefix, so replay it
	task automatic release_held();
		for (int i = 0; i < int'(held_count); i++)
			push_payload(term_byte_at(i));
		held_count = '0;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		int tl;
		int lim;
		tl = active_term_len();
		lim = int'(cur_max_len);
		rx_count = rx_count + tpd_pkg::CNT_W'(1);
		if (tl == 0) begin
			// fixed length: every byte is payload
			held_count = '0;
			push_payload(b);
			if (int'(rx_count) >= lim) begin
				push_marker(1'b0, rx_count);
				rx_count = '0;
			end
		end else begin
			if (int'(held_count) >= tl)
				held_count = '0;
			if (b == term_byte_at(int'(held_count))) begin
				held_count = held_count + 3'(1);
			end else begin
				// mismatch: flush the prefix, then the byte itself with no recheck
				release_held();
				push_payload(b);
			end
			if (int'(held_count) >= tl) begin
				// terminator complete: it is dropped and not counted
				push_marker(1'b1, rx_count - tpd_pkg::CNT_W'(tl));
				rx_count = '0;
				held_count = '0;
			end else if (int'(rx_count) >= lim + tl) begin
				release_held();
				push_marker(1'b0, rx_count);
				rx_count = '0;
			end
		end
	endtask

	function automatic logic [31:0] reg_value(input logic [tpd_pkg::REG_IDX_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			tpd_pkg::REG_MAX_LEN:    r = 32'(cur_max_len);
			tpd_pkg::REG_TERM_LEN:   r = 32'(cur_term_len);
			tpd_pkg::REG_TERM_BYTES: r = cur_term_bytes;
			default:                 r = '0;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// drivers (inputs change on the falling edge)
	// ---------------------------------------------------------------
	// push stays high after an item so back-to-back items need no gap
	task automatic send_rx_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < 20) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		deframe_byte(b);
		@(negedge clk);
	endtask

	// stop sending, wait for every expected result, then let the pipeline empty
	task automatic settle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [tpd_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// any known register abandons the packet in progress
		case (idx)
			tpd_pkg::REG_MAX_LEN:    cur_max_len = value[15:0];
			tpd_pkg::REG_TERM_LEN:   cur_term_len = value[2:0];
			tpd_pkg::REG_TERM_BYTES: cur_term_bytes = value;
			default:                 ;
		endcase
		if (idx != REG_UNUSED) begin
			rx_count = '0;
			held_count = '0;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(input logic [tpd_pkg::REG_IDX_W-1:0] idx);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_value(idx))
			note_error($sformatf("register %0d read %h, expected %h",
				idx, prdata, reg_value(idx)));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_all_regs();
		reg_check(tpd_pkg::REG_MAX_LEN);
		reg_check(tpd_pkg::REG_TERM_LEN);
		reg_check(tpd_pkg::REG_TERM_BYTES);
	endtask

	// ---------------------------------------------------------------
	// result side: random stalls, checking against the oldest expectation
	// ---------------------------------------------------------------
	always @(negedge clk)
		pop <= steady || ($urandom_range(0, 99) >= 20);

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected result: data %h has_data %b last %b",
					data_byte, has_data, last));
			end else begin
				want = pending_results.pop_front();
				if (data_byte !== want.data_byte || has_data !== want.has_data ||
				    last !== want.last || by_terminator !== want.by_terminator ||
				    packet_length !== want.packet_length)
					note_error($sformatf({"result mismatch: got data %h hd %b last %b bt %b len %0d",
						", expected data %h hd %b last %b bt %b len %0d"},
						data_byte, has_data, last, by_terminator, packet_length,
						want.data_byte, want.has_data, want.last, want.by_terminator,
						want.packet_length));
			end
		end
	end

	// watchdog: any handshake or register access counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// reset values, and a one byte packet in the default fixed mode
	task automatic test_reset_values();
		check_all_regs();
		send_rx_byte(8'h00);
	endtask

	task automatic test_fixed_length();
		reg_write(tpd_pkg::REG_TERM_LEN, 32'd0);
		reg_write(tpd_pkg::REG_MAX_LEN, 32'd3);
		send_rx_byte(8'hFF);
		send_rx_byte(8'h5A);
		send_rx_byte(8'h01);
		// zero limit: each byte closes its own packet
		reg_write(tpd_pkg::REG_MAX_LEN, 32'd0);
		send_rx_byte(8'h80);
	endtask

	// CR LF terminator; upper terminator bytes set but unused
	task automatic test_terminator_match();
		reg_write(tpd_pkg::REG_MAX_LEN, 32'd4);
		reg_write(tpd_pkg::REG_TERM_LEN, 32'd2);
		reg_write(tpd_pkg::REG_TERM_BYTES, 32'hFFFF_0A0D);
		send_rx_byte(8'h41);
		send_rx_byte(8'h0D);
		send_rx_byte(8'h0A);      // full match
		send_rx_byte(8'h0D);
		send_rx_byte(8'h42);      // mismatch releases the held CR
		send_rx_byte(8'h0D);
		send_rx_byte(8'h0D);      // second CR is not rechecked against byte 0
		settle();                 // sender holds off until everything is out
		send_rx_byte(8'h0A);
		send_rx_byte(8'h0D);      // length limit hit with a byte held
	endtask

	// zero limit in terminated mode ends the packet after term_len bytes
	task automatic test_zero_limit();
		reg_write(tpd_pkg::REG_MAX_LEN, 32'd0);
		reg_write(tpd_pkg::REG_TERM_LEN, 32'd1);
		reg_write(tpd_pkg::REG_TERM_BYTES, 32'h0000_007E);
		send_rx_byte(8'h7E);
		send_rx_byte(8'h11);
	endtask

	// term_len above MAX_TERM saturates; leaves two bytes held for the next test
	task automatic test_long_terminator();
		reg_write(tpd_pkg::REG_MAX_LEN, 32'd65535);
		reg_write(tpd_pkg::REG_TERM_LEN, 32'd7);
		reg_write(tpd_pkg::REG_TERM_BYTES, 32'h4433_2211);
		send_rx_byte(8'h11);
		send_rx_byte(8'h22);
		send_rx_byte(8'h33);
		send_rx_byte(8'h44);
		send_rx_byte(8'h11);
		send_rx_byte(8'h22);
	endtask

	// a write to an unused address must not disturb the held match
	task automatic test_unused_register();
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_rx_byte(8'h33);
		send_rx_byte(8'h44);
		check_all_regs();
		reg_write(tpd_pkg::REG_TERM_BYTES, 32'hFFFF_FFFF);
		check_all_regs();
	endtask

	// framed packets with random content, some broken or cut short
	task automatic send_random_packets(input int want_items, output int sent);
		int tl;
		int plen;
		int cut;
		int roll;
		logic [7:0] b;
		tl = active_term_len();
		sent = 0;
		while (sent < want_items) begin
			plen = $urandom_range(0, (cur_max_len < 16) ? int'(cur_max_len) + 2 : 18);
			for (int i = 0; i < plen; i++) begin
				// bias toward terminator bytes to provoke partial matches
				if (tl != 0 && $urandom_range(0, 99) < 30)
					b = term_byte_at($urandom_range(0, tl - 1));
				else
					b = 8'($urandom_range(0, 255));
				send_rx_byte(b);
			end
			sent += plen;
			roll = $urandom_range(0, 99);
			if (tl != 0 && roll < 75)
				cut = tl;
			else if (tl > 1 && roll < 85)
				cut = $urandom_range(1, tl - 1);
			else
				cut = 0;
			for (int i = 0; i < cut; i++)
				send_rx_byte(term_byte_at(i));
			sent += cut;
		end
	endtask

	task automatic test_random_traffic();
		int total;
		int sent;
		int phase;
		int roll;
		logic [7:0] rb;
		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 65)
				reg_write(tpd_pkg::REG_MAX_LEN, $urandom_range(0, 12));
			else if (roll < 90)
				reg_write(tpd_pkg::REG_MAX_LEN, $urandom_range(13, 200));
			else
				reg_write(tpd_pkg::REG_MAX_LEN, $urandom_range(65000, 65535));
			roll = $urandom_range(0, 99);
			if (roll < 15)
				reg_write(tpd_pkg::REG_TERM_LEN, 32'd0);
			else if (roll < 85)
				reg_write(tpd_pkg::REG_TERM_LEN, $urandom_range(1, 4));
			else
				reg_write(tpd_pkg::REG_TERM_LEN, $urandom_range(5, 7));
			// repeated bytes exercise the no-recheck behavior
			rb = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 20)
				reg_write(tpd_pkg::REG_TERM_BYTES, {4{rb}});
			else
				reg_write(tpd_pkg::REG_TERM_BYTES, $urandom());
			if ($urandom_range(0, 3) == 0)
				check_all_regs();
			steady = (phase == 2);
			send_random_packets($urandom_range(25, 60), sent);
			total += sent;
			if ($urandom_range(0, 5) == 0) begin
				reg_write(REG_UNUSED, $urandom());
				send_random_packets(5, sent);
				total += sent;
			end
			steady = 1'b0;
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_max_len = 16'd1;
		cur_term_len = '0;
		cur_term_bytes = '0;
		rx_count = '0;
		held_count = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_fixed_length();
		test_terminator_match();
		test_zero_limit();
		test_long_terminator();
		test_unused_register();
		test_random_traffic();

		settle();
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
